FILE: sv/pffv_pkg.sv
// Package for the particle force-field velocity core.
// Holds the item structs, register map and default fixed-point format.
// No dependencies.
package pffv_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int ADDR_W        = 6;
    localparam int DATA_W        = 64;

    localparam logic [2:0] REG_ACCEL_MIN  = 3'd0;
    localparam logic [2:0] REG_ACCEL_MAX  = 3'd1;
    localparam logic [2:0] REG_ACCEL_VEC  = 3'd2;
    localparam logic [2:0] REG_GRAV_MIN   = 3'd3;
    localparam logic [2:0] REG_GRAV_MAX   = 3'd4;
    localparam logic [2:0] REG_GRAV_CTR   = 3'd5;
    localparam logic [2:0] REG_GRAV_STR   = 3'd6;
    localparam logic [2:0] REG_FIELD_EN   = 3'd7;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] new_vel_x;
        logic signed [15:0] new_vel_y;
        logic signed [15:0] new_vel_z;
        logic               in_accel_box;
        logic               in_grav_box;
        logic               stopped;
    } out_item_t;

endpackage

FILE: sv/particle_force_field_velocity_core.sv
// Particle force-field velocity core: acceleration box, gravity well, stop test.
// Single module; depends on pffv_pkg.
//
// channel  dir  handshake          word
// s_       in   s_valid/s_ready    in_item_t  position and velocity, Q8.8
// m_       out  m_valid/m_ready    out_item_t updated velocity and flags
// apb      in   psel/penable/...   64-bit registers at 8*index
//
// The root result is RW = 17 + FRAC_BITS bits wide (25 at Q8.8); one word per cycle while m_ready is high.
// The square root takes one result bit per stage and each axis divider one
// quotient bit per stage; these set the depth.
// Reset (synchronous, aresetn low) clears the registers and all stage valids.
// Each stage advances when it is empty or the next stage advances, so a stall
// at m_ready holds every word in place and bubbles collapse.
module particle_force_field_velocity_core
    import pffv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // Squared length has 34 integer bits; scaled by 2^(2F) before the root.
    localparam int SW = 34 + 2 * FRAC_BITS;
    localparam int RW = SW / 2;
    localparam int NW = 31 + FRAC_BITS;
    localparam int QW = 16;
    localparam int ST_SQ0 = 3;
    localparam int ST_DV0 = ST_SQ0 + RW;
    localparam int ST_FIN = ST_DV0 + QW;
    localparam int NS = ST_FIN + 1;

    typedef struct packed {
        logic [2:0][15:0]   vel;
        logic [2:0][16:0]   d;
        logic [2:0][32:0]   sq;
        logic [2:0][30:0]   mag;
        logic [2:0]         neg;
        logic [SW-1:0]      n;
        logic [SW:0]        res;
        logic [2:0][RW:0]   rem;
        logic [2:0][QW-1:0] q;
        logic               acc;
        logic               grav;
        logic               stop;
        logic               frc;
    } pipe_t;

    // ---------------- configuration registers ----------------
    logic [47:0] acc_min_reg, acc_max_reg, acc_vec_reg;
    logic [47:0] grv_min_reg, grv_max_reg, grv_ctr_reg;
    logic [31:0] grv_str_reg;
    logic [1:0]  fen_reg;
    logic [31:0] stop_sq_reg;
    logic        wr_en;
    logic [2:0]  wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign wr_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_min_reg <= '0;
            acc_max_reg <= '0;
            acc_vec_reg <= '0;
            grv_min_reg <= '0;
            grv_max_reg <= '0;
            grv_ctr_reg <= '0;
            grv_str_reg <= '0;
            fen_reg     <= '0;
            stop_sq_reg <= '0;
        end else begin
            // Square the stop distance once per cycle; config is quiet in use.
            stop_sq_reg <= grv_str_reg[31:16] * grv_str_reg[31:16];
            if (wr_en) begin
                case (wr_idx)
                    REG_ACCEL_MIN: acc_min_reg <= pwdata[47:0];
                    REG_ACCEL_MAX: acc_max_reg <= pwdata[47:0];
                    REG_ACCEL_VEC: acc_vec_reg <= pwdata[47:0];
                    REG_GRAV_MIN:  grv_min_reg <= pwdata[47:0];
                    REG_GRAV_MAX:  grv_max_reg <= pwdata[47:0];
                    REG_GRAV_CTR:  grv_ctr_reg <= pwdata[47:0];
                    REG_GRAV_STR:  grv_str_reg <= pwdata[31:0];
                    REG_FIELD_EN:  fen_reg     <= pwdata[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (wr_idx)
            REG_ACCEL_MIN: prdata = {16'd0, acc_min_reg};
            REG_ACCEL_MAX: prdata = {16'd0, acc_max_reg};
            REG_ACCEL_VEC: prdata = {16'd0, acc_vec_reg};
            REG_GRAV_MIN:  prdata = {16'd0, grv_min_reg};
            REG_GRAV_MAX:  prdata = {16'd0, grv_max_reg};
            REG_GRAV_CTR:  prdata = {16'd0, grv_ctr_reg};
            REG_GRAV_STR:  prdata = {32'd0, grv_str_reg};
            REG_FIELD_EN:  prdata = {62'd0, fen_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- helpers ----------------
    function automatic logic in_box(input logic [47:0] lo, input logic [47:0] hi,
                                    input logic [47:0] p);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if ($signed(lo[16*k +: 16]) > $signed(p[16*k +: 16]) ||
                $signed(hi[16*k +: 16]) < $signed(p[16*k +: 16])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        logic [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'h7fff;
        end else if (v < -18'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // ---------------- pipeline ----------------
    pipe_t       pipe_reg  [NS];
    pipe_t       pipe_next [NS];
    logic [NS-1:0] valid_reg;
    logic [NS:0]   rdy;

    assign rdy[NS] = m_ready;
    assign s_ready = rdy[0];

    generate
        for (genvar i = 0; i < NS; i++) begin : g_stage
            assign rdy[i] = ~valid_reg[i] | rdy[i+1];

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[i] <= 1'b0;
                end else if (rdy[i]) begin
                    valid_reg[i] <= (i == 0) ? s_valid : valid_reg[(i == 0) ? 0 : i-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[i]) begin
                    pipe_reg[i] <= pipe_next[i];
                end
            end
        end
    endgenerate

    // Stage 0: box tests, acceleration add, offset to the gravity centre.
    logic [47:0] pos_pk, vel_pk;
    assign pos_pk = {s_data.pos_z, s_data.pos_y, s_data.pos_x};
    assign vel_pk = {s_data.vel_z, s_data.vel_y, s_data.vel_x};

    always_comb begin
        pipe_next[0]      = '0;
        pipe_next[0].acc  = fen_reg[0] & in_box(acc_min_reg, acc_max_reg, pos_pk);
        pipe_next[0].grav = fen_reg[1] & in_box(grv_min_reg, grv_max_reg, pos_pk);
        for (int k = 0; k < 3; k++) begin
            if (pipe_next[0].acc) begin
                pipe_next[0].vel[k] = sat16(18'(signed'(vel_pk[16*k +: 16])) +
                                            18'(signed'(acc_vec_reg[16*k +: 16])));
            end else begin
                pipe_next[0].vel[k] = vel_pk[16*k +: 16];
            end
            pipe_next[0].d[k] = 17'(signed'(grv_ctr_reg[16*k +: 16])) -
                                17'(signed'(pos_pk[16*k +: 16]));
        end
    end

    // Stage 1: squares of the offset and offset times strength.
    logic signed [33:0] sq_full  [3];
    logic signed [32:0] prod_full [3];

    always_comb begin
        pipe_next[1] = pipe_reg[0];
        for (int k = 0; k < 3; k++) begin
            sq_full[k]   = $signed(pipe_reg[0].d[k]) * $signed(pipe_reg[0].d[k]);
            prod_full[k] = $signed(pipe_reg[0].d[k]) * $signed(grv_str_reg[15:0]);
            pipe_next[1].sq[k]  = sq_full[k][32:0];
            pipe_next[1].neg[k] = prod_full[k][32];
            pipe_next[1].mag[k] = prod_full[k][32] ? 31'(-prod_full[k]) : prod_full[k][30:0];
        end
    end

    // Stage 2: squared length, stop test, root set-up.
    logic [33:0] s_sum;

    always_comb begin
        pipe_next[2] = pipe_reg[1];
        s_sum = 34'(pipe_reg[1].sq[0]) + 34'(pipe_reg[1].sq[1]) + 34'(pipe_reg[1].sq[2]);
        pipe_next[2].stop = pipe_reg[1].grav & (s_sum < 34'(stop_sq_reg));
        pipe_next[2].frc  = pipe_reg[1].grav & ~pipe_next[2].stop & (s_sum != '0);
        pipe_next[2].n    = {s_sum, (2*FRAC_BITS)'(0)};
        pipe_next[2].res  = '0;
    end

    // Square root, one result bit per stage.
    generate
        for (genvar k = 0; k < RW; k++) begin : g_sqrt
            localparam int SH = 2 * (RW - 1 - k);
            logic [SW:0] bitv, trial;
            assign bitv  = (SW+1)'(1) << SH;
            assign trial = pipe_reg[ST_SQ0+k-1].res + bitv;

            always_comb begin
                pipe_next[ST_SQ0+k] = pipe_reg[ST_SQ0+k-1];
                if ({1'b0, pipe_reg[ST_SQ0+k-1].n} >= trial) begin
                    pipe_next[ST_SQ0+k].n   = SW'({1'b0, pipe_reg[ST_SQ0+k-1].n} - trial);
                    pipe_next[ST_SQ0+k].res = (pipe_reg[ST_SQ0+k-1].res >> 1) + bitv;
                end else begin
                    pipe_next[ST_SQ0+k].res = pipe_reg[ST_SQ0+k-1].res >> 1;
                end
            end
        end
    endgenerate

    // Per-axis division of |d*strength| << F by the length, one bit per stage.
    generate
        for (genvar k = 0; k < QW; k++) begin : g_div
            localparam int BI = QW - 1 - k;
            logic [RW:0]   len_x;
            logic [NW-1:0] magsh [3];
            logic [RW:0]   r_in  [3];
            logic [RW:0]   t     [3];
            assign len_x = {1'b0, pipe_reg[ST_DV0+k-1].res[RW-1:0]};

            always_comb begin
                pipe_next[ST_DV0+k] = pipe_reg[ST_DV0+k-1];
                for (int j = 0; j < 3; j++) begin
                    magsh[j] = {pipe_reg[ST_DV0+k-1].mag[j], FRAC_BITS'(0)};
                    if (k == 0) begin
                        r_in[j] = (RW+1)'(magsh[j][NW-1:QW]);
                    end else begin
                        r_in[j] = pipe_reg[ST_DV0+k-1].rem[j];
                    end
                    t[j] = {r_in[j][RW-1:0], magsh[j][BI]};
                    if (t[j] >= len_x) begin
                        pipe_next[ST_DV0+k].rem[j] = t[j] - len_x;
                        pipe_next[ST_DV0+k].q[j]   = {pipe_reg[ST_DV0+k-1].q[j][QW-2:0], 1'b1};
                    end else begin
                        pipe_next[ST_DV0+k].rem[j] = t[j];
                        pipe_next[ST_DV0+k].q[j]   = {pipe_reg[ST_DV0+k-1].q[j][QW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // Final stage: apply force or stop, saturate. Doubles as the output register.
    logic signed [17:0] force_v [3];

    always_comb begin
        pipe_next[ST_FIN] = pipe_reg[ST_FIN-1];
        for (int k = 0; k < 3; k++) begin
            force_v[k] = pipe_reg[ST_FIN-1].neg[k] ?
                         -$signed({2'b00, pipe_reg[ST_FIN-1].q[k]}) :
                          $signed({2'b00, pipe_reg[ST_FIN-1].q[k]});
            if (pipe_reg[ST_FIN-1].stop) begin
                pipe_next[ST_FIN].vel[k] = '0;
            end else if (pipe_reg[ST_FIN-1].frc) begin
                pipe_next[ST_FIN].vel[k] = sat16(18'(signed'(pipe_reg[ST_FIN-1].vel[k])) +
                                                 force_v[k]);
            end
        end
    end

    assign m_valid             = valid_reg[ST_FIN];
    assign m_data.new_vel_x    = pipe_reg[ST_FIN].vel[0];
    assign m_data.new_vel_y    = pipe_reg[ST_FIN].vel[1];
    assign m_data.new_vel_z    = pipe_reg[ST_FIN].vel[2];
    assign m_data.in_accel_box = pipe_reg[ST_FIN].acc;
    assign m_data.in_grav_box  = pipe_reg[ST_FIN].grav;
    assign m_data.stopped      = pipe_reg[ST_FIN].stop;

    // ---------------- assertions ----------------
    a_stop_in_grav: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stopped |-> m_data.in_grav_box)
        else $error("stop flagged outside the gravity box");

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stopped |->
        (m_data.new_vel_x == 0 && m_data.new_vel_y == 0 && m_data.new_vel_z == 0))
        else $error("stopped word carries non-zero velocity");

    a_stop_no_force: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_FIN] |-> !(pipe_reg[ST_FIN].stop && pipe_reg[ST_FIN].frc))
        else $error("stop and force both set");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_FIN-1] && !rdy[ST_FIN] |=> valid_reg[ST_FIN-1])
        else $error("word lost from the stage before the output");

endmodule

FILE: tb/sv/pffv_checker.sv
// Checker for the particle force-field velocity core: mirrors the register
// file from the APB port, predicts each word and compares the results.
// Depends on pffv_pkg.
module pffv_checker
    import pffv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_item_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [47:0] acc_min, acc_max, acc_vec, grv_min, grv_max, grv_ctr;
    logic [31:0] grv_str_stop;
    logic [1:0]  enables;
    out_item_t   velocity_q[$];

    function automatic logic signed [15:0] axis(logic [47:0] v, int k);
        return v[16*k +: 16];
    endfunction

    function automatic logic signed [15:0] sat(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return v[15:0];
    endfunction

    function automatic bit boxed(logic [47:0] lo, logic [47:0] hi, longint p[3]);
        for (int k = 0; k < 3; k++)
            if (axis(lo, k) > p[k] || axis(hi, k) < p[k]) return 0;
        return 1;
    endfunction

    function automatic longint unsigned root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic out_item_t update_velocity(in_item_t w);
        out_item_t o;
        longint p[3], v[3], d[3], str, num, f;
        longint unsigned s, stopd, len, mag;
        p = '{w.pos_x, w.pos_y, w.pos_z};
        v = '{w.vel_x, w.vel_y, w.vel_z};
        o = '0;
        o.in_accel_box = enables[0] && boxed(acc_min, acc_max, p);
        if (o.in_accel_box)
            for (int k = 0; k < 3; k++) v[k] = sat(v[k] + axis(acc_vec, k));
        o.in_grav_box = enables[1] && boxed(grv_min, grv_max, p);
        if (o.in_grav_box) begin
            str = $signed(grv_str_stop[15:0]);
            stopd = 64'(grv_str_stop[31:16]);
            s = 0;
            for (int k = 0; k < 3; k++) begin
                d[k] = axis(grv_ctr, k) - p[k];
                s += d[k] * d[k];
            end
            if (s < stopd * stopd) begin
                o.stopped = 1'b1;
                v = '{0, 0, 0};
            end else if (s != 0) begin
                len = root(s << (2 * FRAC_BITS));
                for (int k = 0; k < 3; k++) begin
                    num = d[k] * str;
                    mag = num < 0 ? -num : num;
                    mag = (mag << FRAC_BITS) / len;
                    f = num < 0 ? -longint'(mag) : longint'(mag);
                    v[k] = sat(v[k] + f);
                end
            end
        end
        o.new_vel_x = 16'(v[0]);
        o.new_vel_y = 16'(v[1]);
        o.new_vel_z = 16'(v[2]);
        return o;
    endfunction

    assign pending = velocity_q.size();

    always @(posedge aclk) begin
        out_item_t e;
        if (!aresetn) begin
            acc_min <= '0; acc_max <= '0; acc_vec <= '0;
            grv_min <= '0; grv_max <= '0; grv_ctr <= '0;
            grv_str_stop <= '0; enables <= '0;
            velocity_q.delete();
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_ACCEL_MIN: acc_min <= pwdata[47:0];
                    REG_ACCEL_MAX: acc_max <= pwdata[47:0];
                    REG_ACCEL_VEC: acc_vec <= pwdata[47:0];
                    REG_GRAV_MIN:  grv_min <= pwdata[47:0];
                    REG_GRAV_MAX:  grv_max <= pwdata[47:0];
                    REG_GRAV_CTR:  grv_ctr <= pwdata[47:0];
                    REG_GRAV_STR:  grv_str_stop <= pwdata[31:0];
                    REG_FIELD_EN:  enables <= pwdata[1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (velocity_q.size() == 0) begin
                    $error("unexpected result word %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    e = velocity_q.pop_front();
                    if (e != m_data) begin
                        if (e.new_vel_x != m_data.new_vel_x)
                            $error("new_vel_x exp %0d got %0d", e.new_vel_x, m_data.new_vel_x);
                        if (e.new_vel_y != m_data.new_vel_y)
                            $error("new_vel_y exp %0d got %0d", e.new_vel_y, m_data.new_vel_y);
                        if (e.new_vel_z != m_data.new_vel_z)
                            $error("new_vel_z exp %0d got %0d", e.new_vel_z, m_data.new_vel_z);
                        if (e.in_accel_box != m_data.in_accel_box)
                            $error("in_accel_box exp %0b got %0b", e.in_accel_box,
                                   m_data.in_accel_box);
                        if (e.in_grav_box != m_data.in_grav_box)
                            $error("in_grav_box exp %0b got %0b", e.in_grav_box,
                                   m_data.in_grav_box);
                        if (e.stopped != m_data.stopped)
                            $error("stopped exp %0b got %0b", e.stopped, m_data.stopped);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Queue the prediction at the tail.
            if (s_valid && s_ready)
                velocity_q.insert(velocity_q.size(), update_velocity(s_data));
        end
    end
endmodule

FILE: tb/sv/tb.sv
// Top of the testbench for the particle force-field velocity core.
// Depends on pffv_pkg, particle_force_field_velocity_core and pffv_checker.
module tb
    import pffv_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = 4 + 17 + FRAC_BITS_DEF + 16;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 150;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, m_valid, m_ready = 0;
    in_item_t s_data = '0;
    out_item_t m_data;
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0, prdata;
    int fail_count, pending;
    int idle_cycles;
    bit calm;       // no idling during the closing stretch

    always #4 aclk = ~aclk;

    particle_force_field_velocity_core u_top (.*);

    pffv_checker u_chk (.*);

    // Watchdog: count cycles in which no word moves on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: stall in random bursts, never during the calm stretch.
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
    end

    // Write one register through the APB port: setup then access.
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Present one word, hold it until accepted, then maybe idle.
    task automatic send_word(in_item_t w);
        s_valid <= 1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    // Let the pipe drain before touching registers.
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_lane();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 255) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_vec();
        return {rand_lane(), rand_lane(), rand_lane()};
    endfunction

    // Box corners from a random centre and half-width, clamped per lane.
    task automatic rand_box(output logic [47:0] lo, output logic [47:0] hi);
        int c, h;
        for (int k = 0; k < 3; k++) begin
            c = $signed(16'($urandom));
            h = $urandom_range(0, 20000);
            lo[16*k +: 16] = 16'((c - h < -32768) ? -32768 : c - h);
            hi[16*k +: 16] = 16'((c + h > 32767) ? 32767 : c + h);
        end
        if ($urandom_range(0, 7) == 0) {lo, hi} = {hi, lo};   // empty box now and then
    endtask

    // Bias positions toward the gravity centre and the lane extremes.
    function automatic in_item_t rand_word(logic [47:0] ctr);
        in_item_t w;
        logic [15:0] p[3];
        for (int k = 0; k < 3; k++)
            case ($urandom_range(0, 3))
                0: p[k] = 16'(ctr[16*k +: 16] + $urandom_range(0, 1024) - 512);
                1: p[k] = rand_lane();
                default: p[k] = $signed(16'($urandom)) >>> $urandom_range(0, 4);
            endcase
        w.pos_x = p[0]; w.pos_y = p[1]; w.pos_z = p[2];
        w.vel_x = rand_lane(); w.vel_y = rand_lane(); w.vel_z = rand_lane();
        return w;
    endfunction

    initial begin
        logic [47:0] lo, hi, ctr;
        in_item_t w;
        calm = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset settings (fields off), extremes pass straight through.
        send_word('{16'h8000, 16'h7fff, 0, 16'h7fff, 16'h8000, 0});
        send_word('{16'h7fff, 16'h8000, 16'hffff, 16'h8000, 16'h7fff, 16'h0001});
        drain();

        // Directed: whole-range boxes, saturating acceleration, gravity centre at origin.
        write_reg(REG_ACCEL_MIN, {16'h8000, 16'h8000, 16'h8000});
        write_reg(REG_ACCEL_MAX, {16'h7fff, 16'h7fff, 16'h7fff});
        write_reg(REG_ACCEL_VEC, {16'h7fff, 16'h8000, 16'h0100});
        write_reg(REG_GRAV_MIN, {16'h8000, 16'h8000, 16'h8000});
        write_reg(REG_GRAV_MAX, {16'h7fff, 16'h7fff, 16'h7fff});
        write_reg(REG_GRAV_CTR, '0);
        write_reg(REG_GRAV_STR, {16'h0200, 16'h8000});
        write_reg(REG_FIELD_EN, 2'b11);
        send_word('{0, 0, 0, 16'h7fff, 16'h8000, 0});              // zero length, stop
        send_word('{16'h0100, 0, 0, 16'h1000, 0, 0});              // inside stop distance
        send_word('{16'h0200, 0, 0, 0, 0, 0});                     // exactly at stop distance
        send_word('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 0});
        send_word('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
        drain();
        write_reg(REG_GRAV_STR, {16'h0000, 16'h7fff});             // stop distance zero
        write_reg(REG_ACCEL_MIN, {16'h0000, 16'h0001, 16'h0000});  // empty on y
        write_reg(REG_ACCEL_MAX, '0);
        send_word('{0, 0, 0, 16'h0100, 16'h0100, 16'h0100});       // zero length adds nothing
        send_word('{0, 0, 0, 1, 2, 3});                            // empty accel box
        send_word('{16'h8000, 16'h7fff, 16'h8000, 0, 0, 0});
        drain();
        write_reg(REG_FIELD_EN, 2'b10);
        send_word('{16'h0300, 16'hfd00, 16'h0001, 0, 0, 0});
        drain();
        write_reg(REG_FIELD_EN, 2'b01);
        write_reg(REG_ACCEL_MIN, '0);
        send_word('{0, 0, 0, 16'h0005, 16'h0006, 16'h0007});       // inclusive bounds
        drain();

        // Random phases with fresh settings; last phase runs without idling.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            rand_box(lo, hi);
            write_reg(REG_ACCEL_MIN, lo);
            write_reg(REG_ACCEL_MAX, hi);
            write_reg(REG_ACCEL_VEC, rand_vec());
            rand_box(lo, hi);
            write_reg(REG_GRAV_MIN, lo);
            write_reg(REG_GRAV_MAX, hi);
            ctr = rand_vec();
            write_reg(REG_GRAV_CTR, ctr);
            write_reg(REG_GRAV_STR, {16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2048)),
                                     rand_lane()});
            write_reg(REG_FIELD_EN, ph < 4 ? 2'(ph) : 2'b11);
            if (ph == NUM_PHASES - 1) calm = 1;
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                w = rand_word(ctr);
                send_word(w);
            end
            drain();
        end

        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: files.f
sv/pffv_pkg.sv
sv/particle_force_field_velocity_core.sv
tb/sv/pffv_checker.sv
tb/sv/tb.sv
